### hw/rtl/hhfp_pkg.sv
`timescale 1ns / 1ps

package hhfp_pkg;

    localparam int OVERFLOW_SLOTS = 16;
    localparam int SLOT_W         = $clog2(OVERFLOW_SLOTS + 1);
    localparam int LIMIT_W        = 5;
    localparam int CMP_W          = (SLOT_W > LIMIT_W) ? SLOT_W : LIMIT_W;

    localparam int KNOWN_COUNT = 9;
    localparam int ID_W        = 4;
    localparam int POS_W       = 16;
    localparam int HASH_W      = 32;

    localparam logic [ID_W-1:0]   ID_UNKNOWN = 4'd9;
    localparam logic [SLOT_W-1:0] NO_SLOT    = SLOT_W'(OVERFLOW_SLOTS);
    localparam logic [4:0]        LINK_KNOWN = 5'd16;
    localparam logic [4:0]        LINK_NONE  = 5'd17;

    localparam logic [HASH_W-1:0] HASH_MUL = 32'h5bd1e995;
    localparam int                HASH_SHIFT = 15;

    localparam logic [HASH_W-1:0] KNOWN_HASH [KNOWN_COUNT] = '{
        32'h1e5aeec4, 32'h240bbc50, 32'h41141d0c, 32'hc947e5d0, 32'h8fd8a976,
        32'h8210d858, 32'h60f97fde, 32'h4def559a, 32'ha13e549b
    };

    // event kinds
    localparam logic [1:0] EV_KEY      = 2'd0;
    localparam logic [1:0] EV_VALUE    = 2'd1;
    localparam logic [1:0] EV_COMPLETE = 2'd2;
    localparam logic [1:0] EV_ERROR    = 2'd3;

    // error codes
    localparam logic ERR_BAD_REQUEST = 1'b0;
    localparam logic ERR_TOO_LARGE   = 1'b1;

    // configuration register indexes
    localparam logic CFG_HASH_SEED      = 1'b0;
    localparam logic CFG_OVERFLOW_LIMIT = 1'b1;

    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_TILDE = 8'h7e;

    typedef struct packed {
        logic [1:0]        event_kind;
        logic [ID_W-1:0]   header_id;
        logic              in_overflow;
        logic [3:0]        slot_index;
        logic [4:0]        link_after;
        logic [POS_W-1:0]  span_start;
        logic [POS_W-1:0]  span_length;
        logic [HASH_W-1:0] key_hash;
        logic              error_code;
    } hhfp_result_t;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  data_byte;
        logic [POS_W-1:0] start_position;
    } hhfp_item_t;

endpackage

### hw/rtl/hhfp_key_hash.sv
`timescale 1ns / 1ps

module hhfp_key_hash
    import hhfp_pkg::*;
(
    input  logic [HASH_W-1:0] hash_in,
    input  logic [7:0]        key_char,
    output logic [HASH_W-1:0] hash_out
);

    logic [7:0]        lower_char;
    logic [HASH_W-1:0] mixed;
    logic [HASH_W-1:0] product;

    always_comb
    begin
        // fold upper case to lower case
        if (key_char >= 8'h41 && key_char <= 8'h5a)
        begin
            lower_char = key_char + 8'd32;
        end
        else
        begin
            lower_char = key_char;
        end
        mixed    = hash_in ^ {24'd0, lower_char};
        product  = mixed * HASH_MUL;
        hash_out = product ^ (product >> HASH_SHIFT);
    end

endmodule

### hw/rtl/hhfp_parser.sv
`timescale 1ns / 1ps

module hhfp_parser
    import hhfp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         step_en,
    input  hhfp_item_t   item,
    output logic         res_valid,
    output hhfp_result_t res
);

    localparam logic [2:0] PH_KEY      = 3'd0;
    localparam logic [2:0] PH_VALUE    = 3'd1;
    localparam logic [2:0] PH_CR       = 3'd2;
    localparam logic [2:0] PH_LF       = 3'd3;
    localparam logic [2:0] PH_DECISION = 3'd4;
    localparam logic [2:0] PH_COMPLETE = 3'd5;
    localparam logic [2:0] PH_ERROR    = 3'd6;

    logic [HASH_W-1:0]  hash_seed_reg;
    logic [LIMIT_W-1:0] overflow_limit_reg;

    logic [2:0]         phase_reg, phase_next;
    logic [POS_W-1:0]   position_reg, position_next;
    logic [POS_W-1:0]   key_begin_reg, key_begin_next;
    logic [POS_W-1:0]   value_begin_reg, value_begin_next;
    logic [HASH_W-1:0]  hash_reg, hash_next;
    logic               blank_reg, blank_next;
    logic               skipping_reg, skipping_next;
    logic [ID_W-1:0]    active_header_reg, active_header_next;
    logic [SLOT_W-1:0]  active_ovf_reg, active_ovf_next;
    logic [SLOT_W-1:0]  used_reg, used_next;
    logic [KNOWN_COUNT-1:0] taken_reg, taken_next;
    logic [SLOT_W-1:0]  tail_reg [KNOWN_COUNT];
    logic [SLOT_W-1:0]  tail_next [KNOWN_COUNT];

    logic [7:0]         c;
    logic               in_decision;
    logic [HASH_W-1:0]  hash_eff;
    logic [POS_W-1:0]   key_begin_eff;
    logic [POS_W-1:0]   value_begin_eff;
    logic [POS_W-1:0]   position_inc;
    logic [HASH_W-1:0]  hash_stepped;
    logic               known_hit;
    logic [ID_W-1:0]    hit_id;
    logic               is_token;
    logic [CMP_W-1:0]   limit_eff;
    logic               slots_full;
    logic               value_ovf;
    logic [SLOT_W-1:0]  hit_tail;

    assign c             = item.data_byte;
    assign in_decision   = (phase_reg == PH_DECISION);
    assign hash_eff      = in_decision ? hash_seed_reg : hash_reg;
    assign key_begin_eff = in_decision ? position_reg : key_begin_reg;
    assign position_inc  = position_reg + 1'b1;

    hhfp_key_hash u_key_hash (
        .hash_in  (hash_eff),
        .key_char (c),
        .hash_out (hash_stepped)
    );

    // lowest matching entry wins
    always_comb
    begin
        known_hit = 1'b0;
        hit_id    = ID_UNKNOWN;
        for (int i = KNOWN_COUNT - 1; i >= 0; i--)
        begin
            if (KNOWN_HASH[i] == hash_eff)
            begin
                known_hit = 1'b1;
                hit_id    = ID_W'(i);
            end
        end
    end

    always_comb
    begin
        is_token = 1'b0;
        if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7a) ||
            (c >= 8'h41 && c <= 8'h5a))
        begin
            is_token = 1'b1;
        end
        else
        begin
            case (c)
                8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2a, 8'h2b,
                8'h2d, 8'h2e, 8'h5e, 8'h5f, 8'h60, 8'h7c, 8'h7e:
                    is_token = 1'b1;
                default:
                    is_token = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        if (CMP_W'(overflow_limit_reg) > CMP_W'(OVERFLOW_SLOTS))
        begin
            limit_eff = CMP_W'(OVERFLOW_SLOTS);
        end
        else
        begin
            limit_eff = CMP_W'(overflow_limit_reg);
        end
        slots_full = (CMP_W'(used_reg) >= limit_eff);
    end

    assign hit_tail  = tail_reg[hit_id[$clog2(KNOWN_COUNT)-1:0]];
    assign value_ovf = (active_ovf_reg != NO_SLOT);
    assign value_begin_eff = skipping_reg ? position_reg : value_begin_reg;

    always_comb
    begin
        phase_next         = phase_reg;
        position_next      = position_reg;
        key_begin_next     = key_begin_reg;
        value_begin_next   = value_begin_reg;
        hash_next          = hash_reg;
        blank_next         = blank_reg;
        skipping_next      = skipping_reg;
        active_header_next = active_header_reg;
        active_ovf_next    = active_ovf_reg;
        used_next          = used_reg;
        taken_next         = taken_reg;
        tail_next          = tail_reg;
        res_valid          = 1'b0;
        res                = '0;

        if (item.cmd)
        begin
            phase_next         = PH_KEY;
            position_next      = item.start_position;
            key_begin_next     = item.start_position;
            value_begin_next   = item.start_position;
            hash_next          = hash_seed_reg;
            blank_next         = 1'b0;
            skipping_next      = 1'b0;
            active_header_next = ID_UNKNOWN;
            active_ovf_next    = NO_SLOT;
            used_next          = '0;
            taken_next         = '0;
            for (int i = 0; i < KNOWN_COUNT; i++)
            begin
                tail_next[i] = NO_SLOT;
            end
        end
        else
        begin
            case (phase_reg)
                PH_KEY, PH_DECISION:
                begin
                    if (in_decision && c == CH_CR)
                    begin
                        blank_next    = 1'b1;
                        position_next = position_inc;
                        phase_next    = PH_LF;
                    end
                    else
                    begin
                        // a new line starts a fresh key
                        blank_next         = 1'b0;
                        key_begin_next     = key_begin_eff;
                        hash_next          = hash_eff;
                        active_header_next = ID_UNKNOWN;
                        active_ovf_next    = NO_SLOT;
                        phase_next         = PH_KEY;
                        if (c == CH_COLON)
                        begin
                            position_next      = position_inc;
                            active_header_next = hit_id;
                            res.event_kind     = EV_KEY;
                            res.header_id      = hit_id;
                            res.link_after     = LINK_NONE;
                            res.span_start     = key_begin_eff;
                            res.span_length    = position_reg - key_begin_eff;
                            res.key_hash       = hash_eff;
                            res_valid          = 1'b1;
                            if (known_hit && !taken_reg[hit_id[$clog2(KNOWN_COUNT)-1:0]])
                            begin
                                taken_next[hit_id[$clog2(KNOWN_COUNT)-1:0]] = 1'b1;
                            end
                            else if (!slots_full)
                            begin
                                active_ovf_next = used_reg;
                                res.in_overflow = 1'b1;
                                res.slot_index  = 4'(used_reg);
                                if (known_hit)
                                begin
                                    res.link_after = (hit_tail == NO_SLOT) ? LINK_KNOWN
                                                                           : 5'(hit_tail);
                                    tail_next[hit_id[$clog2(KNOWN_COUNT)-1:0]] = used_reg;
                                end
                            end
                            if (!(known_hit && !taken_reg[hit_id[$clog2(KNOWN_COUNT)-1:0]])
                                && slots_full)
                            begin
                                phase_next     = PH_ERROR;
                                res            = '0;
                                res.event_kind = EV_ERROR;
                                res.error_code = ERR_TOO_LARGE;
                            end
                            else
                            begin
                                hash_next     = hash_seed_reg;
                                skipping_next = 1'b1;
                                phase_next    = PH_VALUE;
                            end
                        end
                        else if (!is_token)
                        begin
                            phase_next     = PH_ERROR;
                            res_valid      = 1'b1;
                            res.event_kind = EV_ERROR;
                            res.error_code = ERR_BAD_REQUEST;
                        end
                        else
                        begin
                            hash_next     = hash_stepped;
                            position_next = position_inc;
                        end
                    end
                end

                PH_VALUE:
                begin
                    if (skipping_reg && (c == CH_SPACE || c == CH_TAB))
                    begin
                        position_next = position_inc;
                    end
                    else
                    begin
                        value_begin_next = value_begin_eff;
                        skipping_next    = 1'b0;
                        if (c == CH_CR)
                        begin
                            if (value_ovf && (CMP_W'(used_reg) < CMP_W'(OVERFLOW_SLOTS)))
                            begin
                                used_next = used_reg + 1'b1;
                            end
                            position_next   = position_inc;
                            phase_next      = PH_LF;
                            res_valid       = 1'b1;
                            res.event_kind  = EV_VALUE;
                            res.header_id   = active_header_reg;
                            res.in_overflow = value_ovf;
                            res.slot_index  = value_ovf ? 4'(active_ovf_reg) : 4'd0;
                            res.link_after  = LINK_NONE;
                            res.span_start  = value_begin_eff;
                            res.span_length = position_reg - value_begin_eff;
                        end
                        else if (c < CH_SPACE || c > CH_TILDE)
                        begin
                            phase_next     = PH_ERROR;
                            res_valid      = 1'b1;
                            res.event_kind = EV_ERROR;
                            res.error_code = ERR_BAD_REQUEST;
                        end
                        else
                        begin
                            position_next = position_inc;
                        end
                    end
                end

                PH_CR:
                begin
                    if (c != CH_CR)
                    begin
                        phase_next     = PH_ERROR;
                        res_valid      = 1'b1;
                        res.event_kind = EV_ERROR;
                        res.error_code = ERR_BAD_REQUEST;
                    end
                    else
                    begin
                        position_next = position_inc;
                        phase_next    = PH_LF;
                    end
                end

                PH_LF:
                begin
                    if (c != CH_LF)
                    begin
                        phase_next     = PH_ERROR;
                        res_valid      = 1'b1;
                        res.event_kind = EV_ERROR;
                        res.error_code = ERR_BAD_REQUEST;
                    end
                    else
                    begin
                        position_next = position_inc;
                        if (blank_reg)
                        begin
                            phase_next     = PH_COMPLETE;
                            res_valid      = 1'b1;
                            res.event_kind = EV_COMPLETE;
                            res.span_start = position_inc;
                        end
                        else
                        begin
                            phase_next = PH_DECISION;
                        end
                    end
                end

                default:
                begin
                    // complete or error: drop bytes until a new block
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_seed_reg      <= '0;
            overflow_limit_reg <= LIMIT_W'(16);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HASH_SEED:      hash_seed_reg      <= cfg_data;
                CFG_OVERFLOW_LIMIT: overflow_limit_reg <= cfg_data[LIMIT_W-1:0];
                default:            hash_seed_reg      <= hash_seed_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_KEY;
            position_reg      <= '0;
            key_begin_reg     <= '0;
            value_begin_reg   <= '0;
            hash_reg          <= '0;
            blank_reg         <= 1'b0;
            skipping_reg      <= 1'b0;
            active_header_reg <= ID_UNKNOWN;
            active_ovf_reg    <= NO_SLOT;
            used_reg          <= '0;
            taken_reg         <= '0;
            for (int i = 0; i < KNOWN_COUNT; i++)
            begin
                tail_reg[i] <= NO_SLOT;
            end
        end
        else if (step_en)
        begin
            phase_reg         <= phase_next;
            position_reg      <= position_next;
            key_begin_reg     <= key_begin_next;
            value_begin_reg   <= value_begin_next;
            hash_reg          <= hash_next;
            blank_reg         <= blank_next;
            skipping_reg      <= skipping_next;
            active_header_reg <= active_header_next;
            active_ovf_reg    <= active_ovf_next;
            used_reg          <= used_next;
            taken_reg         <= taken_next;
            tail_reg          <= tail_next;
        end
    end

endmodule

### hw/rtl/http_header_field_parser_unit.sv
`timescale 1ns / 1ps

// Channel  Handshake                 Payload
// in       in_valid / in_stall        cmd, data_byte, start_position
// out      out_valid / out_stall      event_kind .. error_code
// cfg      cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One byte per cycle unless a held result stalls: an input register feeds the
// parser step (hash multiply, known-header compare, phase update) straight into
// the result register.
// Reset clears the parser to the key phase with seed 0 and a limit of 16.
// A held result stalls the step; the input register then holds its byte.

module http_header_field_parser_unit
    import hhfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic              cmd,
    input  logic [7:0]        data_byte,
    input  logic [POS_W-1:0]  start_position,

    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        event_kind,
    output logic [ID_W-1:0]   header_id,
    output logic              in_overflow,
    output logic [3:0]        slot_index,
    output logic [4:0]        link_after,
    output logic [POS_W-1:0]  span_start,
    output logic [POS_W-1:0]  span_length,
    output logic [HASH_W-1:0] key_hash,
    output logic              error_code,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [31:0]       cfg_data
);

    logic         in_vld_reg;
    hhfp_item_t   item_reg;
    logic         out_vld_reg;
    hhfp_result_t res_reg;
    logic         step_en;
    logic         res_valid;
    hhfp_result_t res;

    assign cfg_ready = 1'b1;
    assign step_en   = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && !step_en;

    hhfp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step_en   (step_en),
        .item      (item_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (step_en)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.cmd            <= cmd;
            item_reg.data_byte      <= data_byte;
            item_reg.start_position <= start_position;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (step_en && res_valid)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid   = out_vld_reg;
    assign event_kind  = res_reg.event_kind;
    assign header_id   = res_reg.header_id;
    assign in_overflow = res_reg.in_overflow;
    assign slot_index  = res_reg.slot_index;
    assign link_after  = res_reg.link_after;
    assign span_start  = res_reg.span_start;
    assign span_length = res_reg.span_length;
    assign key_hash    = res_reg.key_hash;
    assign error_code  = res_reg.error_code;

endmodule

### tb/http_header_field_parser_unit_tb.sv
`timescale 1ns / 1ps

module http_header_field_parser_unit_tb;
    import hhfp_pkg::*;

    typedef enum logic [2:0] {
        PH_KEY,
        PH_VALUE,
        PH_CR,
        PH_LF,
        PH_DECISION,
        PH_COMPLETE,
        PH_ERROR
    } parse_stage_t;

    localparam logic [31:0] MIX_MUL   = 32'h5bd1e995;
    localparam int          MIX_SHIFT = 15;
    localparam logic [31:0] HEADER_HASH [KNOWN_COUNT] = '{
        32'h1e5aeec4, 32'h240bbc50, 32'h41141d0c, 32'hc947e5d0, 32'h8fd8a976,
        32'h8210d858, 32'h60f97fde, 32'h4def559a, 32'ha13e549b
    };

    class header_scoreboard;
        logic [31:0]       seed;
        logic [4:0]        limit;
        parse_stage_t      stage;
        logic [15:0]       pos;
        logic [15:0]       key_start;
        logic [15:0]       value_start;
        logic [31:0]       hash;
        bit                blank_seen;
        bit                skip_ws;
        logic [3:0]        cur_id;
        logic [SLOT_W-1:0] cur_slot;
        logic [SLOT_W-1:0] used;
        bit                taken [KNOWN_COUNT];
        logic [SLOT_W-1:0] tail [KNOWN_COUNT];
        hhfp_result_t      expected_events [$];
        int                errors;

        function new();
            seed   = '0;
            limit  = 5'd16;
            errors = 0;
            restart(16'd0);
        endfunction

        static function bit is_token(logic [7:0] c);
            if ((c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
                return 1'b1;
            case (c)
                8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2a, 8'h2b,
                8'h2d, 8'h2e, 8'h5e, 8'h5f, 8'h60, 8'h7c, 8'h7e: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function logic [31:0] mix(logic [31:0] h, logic [7:0] c);
            logic [31:0] m;
            m = (h ^ {24'd0, c}) * MIX_MUL;
            return m ^ (m >> MIX_SHIFT);
        endfunction

        function void write_config(logic idx, logic [31:0] v);
            if (idx == CFG_HASH_SEED)
                seed = v;
            else
                limit = v[4:0];
        endfunction

        function void restart(logic [15:0] start);
            stage       = PH_KEY;
            pos         = start;
            key_start   = start;
            value_start = start;
            hash        = seed;
            blank_seen  = 1'b0;
            skip_ws     = 1'b0;
            cur_id      = ID_UNKNOWN;
            cur_slot    = NO_SLOT;
            used        = '0;
            for (int i = 0; i < KNOWN_COUNT; i++)
            begin
                taken[i] = 1'b0;
                tail[i]  = NO_SLOT;
            end
        endfunction

        function void expect_event(logic [1:0] kind, logic [3:0] id, logic ovf,
                                   logic [3:0] slot, logic [4:0] link, logic [15:0] start,
                                   logic [15:0] len, logic [31:0] h, logic err);
            hhfp_result_t r;
            r.event_kind  = kind;
            r.header_id   = id;
            r.in_overflow = ovf;
            r.slot_index  = slot;
            r.link_after  = link;
            r.span_start  = start;
            r.span_length = len;
            r.key_hash    = h;
            r.error_code  = err;
            expected_events.push_back(r);
        endfunction

        function void fail(logic code);
            stage = PH_ERROR;
            expect_event(EV_ERROR, '0, 1'b0, '0, '0, '0, '0, '0, code);
        endfunction

        function void key_byte(logic [7:0] c);
            logic [3:0]  id;
            logic [4:0]  link;
            logic [15:0] len;
            logic [31:0] final_hash;
            int          eff_limit;
            bit          ovf;
            if (c == CH_COLON)
            begin
                id         = ID_UNKNOWN;
                link       = LINK_NONE;
                len        = pos - key_start;
                final_hash = hash;
                for (int i = 0; i < KNOWN_COUNT; i++)
                    if (id == ID_UNKNOWN && HEADER_HASH[i] == final_hash)
                        id = 4'(i);
                pos      = pos + 16'd1;
                cur_id   = id;
                cur_slot = NO_SLOT;
                if (id < KNOWN_COUNT && !taken[id])
                    taken[id] = 1'b1;
                else
                begin
                    eff_limit = (limit > OVERFLOW_SLOTS) ? OVERFLOW_SLOTS : int'(limit);
                    if (int'(used) >= eff_limit)
                    begin
                        fail(ERR_TOO_LARGE);
                        return;
                    end
                    cur_slot = used;
                    if (id < KNOWN_COUNT)
                    begin
                        link     = (tail[id] == NO_SLOT) ? LINK_KNOWN : 5'(tail[id]);
                        tail[id] = cur_slot;
                    end
                end
                hash    = seed;
                skip_ws = 1'b1;
                stage   = PH_VALUE;
                ovf     = (cur_slot != NO_SLOT);
                expect_event(EV_KEY, id, ovf, ovf ? cur_slot[3:0] : 4'd0, link, key_start,
                             len, final_hash, 1'b0);
            end
            else if (!is_token(c))
                fail(ERR_BAD_REQUEST);
            else
            begin
                if (c >= "A" && c <= "Z")
                    c = c + 8'd32;
                hash = mix(hash, c);
                pos  = pos + 16'd1;
            end
        endfunction

        function void value_byte(logic [7:0] c);
            bit ovf;
            if (skip_ws)
            begin
                if (c == CH_SPACE || c == CH_TAB)
                begin
                    pos = pos + 16'd1;
                    return;
                end
                value_start = pos;
                skip_ws     = 1'b0;
            end
            if (c == CH_CR)
            begin
                ovf = (cur_slot != NO_SLOT);
                if (ovf && used < OVERFLOW_SLOTS)
                    used = used + 1'b1;
                expect_event(EV_VALUE, cur_id, ovf, ovf ? cur_slot[3:0] : 4'd0, LINK_NONE,
                             value_start, pos - value_start, '0, 1'b0);
                pos   = pos + 16'd1;
                stage = PH_LF;
            end
            else if (c < CH_SPACE || c > CH_TILDE)
                fail(ERR_BAD_REQUEST);
            else
                pos = pos + 16'd1;
        endfunction

        // Returns 1 when the transaction is not simply dropped by the parser.
        function bit accept_item(hhfp_item_t it);
            logic [7:0] c;
            c = it.data_byte;
            if (it.cmd)
            begin
                restart(it.start_position);
                return 1'b1;
            end
            case (stage)
                PH_KEY:   key_byte(c);
                PH_VALUE: value_byte(c);
                PH_CR:
                begin
                    if (c != CH_CR)
                        fail(ERR_BAD_REQUEST);
                    else
                    begin
                        pos   = pos + 16'd1;
                        stage = PH_LF;
                    end
                end
                PH_LF:
                begin
                    if (c != CH_LF)
                        fail(ERR_BAD_REQUEST);
                    else
                    begin
                        pos = pos + 16'd1;
                        if (blank_seen)
                        begin
                            stage = PH_COMPLETE;
                            expect_event(EV_COMPLETE, '0, 1'b0, '0, '0, pos, '0, '0, 1'b0);
                        end
                        else
                            stage = PH_DECISION;
                    end
                end
                PH_DECISION:
                begin
                    if (c == CH_CR)
                    begin
                        blank_seen = 1'b1;
                        pos        = pos + 16'd1;
                        stage      = PH_LF;
                    end
                    else
                    begin
                        blank_seen = 1'b0;
                        key_start  = pos;
                        hash       = seed;
                        cur_id     = ID_UNKNOWN;
                        cur_slot   = NO_SLOT;
                        stage      = PH_KEY;
                        key_byte(c);
                    end
                end
                default: return 1'b0;
            endcase
            return 1'b1;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_event(hhfp_result_t got);
            hhfp_result_t want;
            if (expected_events.size() == 0)
            begin
                $error("result transaction with nothing expected: kind %0d", got.event_kind);
                errors++;
                return;
            end
            want = expected_events.pop_front();
            compare_field("event_kind", want.event_kind, got.event_kind);
            compare_field("header_id", want.header_id, got.header_id);
            compare_field("in_overflow", want.in_overflow, got.in_overflow);
            compare_field("slot_index", want.slot_index, got.slot_index);
            compare_field("link_after", want.link_after, got.link_after);
            compare_field("span_start", want.span_start, got.span_start);
            compare_field("span_length", want.span_length, got.span_length);
            compare_field("key_hash", want.key_hash, got.key_hash);
            compare_field("error_code", want.error_code, got.error_code);
        endfunction

        function void flag_leftovers();
            if (expected_events.size() != 0)
            begin
                $error("%0d expected results never arrived", expected_events.size());
                errors += expected_events.size();
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid;
    logic              in_stall;
    logic              cmd;
    logic [7:0]        data_byte;
    logic [POS_W-1:0]  start_position;
    logic              out_valid;
    logic              out_stall;
    logic [1:0]        event_kind;
    logic [ID_W-1:0]   header_id;
    logic              in_overflow;
    logic [3:0]        slot_index;
    logic [4:0]        link_after;
    logic [POS_W-1:0]  span_start;
    logic [POS_W-1:0]  span_length;
    logic [HASH_W-1:0] key_hash;
    logic              error_code;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_index;
    logic [31:0]       cfg_data;

    header_scoreboard parser_sb;
    int               fed;
    bit               in_burst;

    string known_names [KNOWN_COUNT] = '{
        "host", "content-length", "transfer-encoding", "content-type", "connection",
        "expect", "authorization", "cookie", "accept-encoding"
    };

    http_header_field_parser_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .data_byte      (data_byte),
        .start_position (start_position),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_kind     (event_kind),
        .header_id      (header_id),
        .in_overflow    (in_overflow),
        .slot_index     (slot_index),
        .link_after     (link_after),
        .span_start     (span_start),
        .span_length    (span_length),
        .key_hash       (key_hash),
        .error_code     (error_code),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #6 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        hhfp_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{event_kind, header_id, in_overflow, slot_index, link_after,
                    span_start, span_length, key_hash, error_code};
            parser_sb.check_event(got);
        end
    end

    // Result side: random stalls, bursts without stalls, and two long hold-offs
    // that back the parser up into its input.
    initial
    begin
        int hold;
        int results_taken;
        bit out_burst;
        out_stall <= 1'b0;
        results_taken = 0;
        out_burst = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (results_taken == 30 || results_taken == 80)
                hold = 90;
            else
                hold = out_burst ? 0 : $urandom_range(0, 10);
            if ($urandom_range(0, 39) == 0)
                out_burst = !out_burst;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            results_taken++;
        end
    end

    task automatic send_item(input logic c, input logic [7:0] b, input logic [15:0] sp);
        int gap;
        hhfp_item_t it;
        gap = in_burst ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 39) == 0)
            in_burst = !in_burst;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        cmd            <= c;
        data_byte      <= b;
        start_position <= sp;
        do @(posedge clk); while (in_stall);
        it = '{c, b, sp};
        if (parser_sb.accept_item(it))
            fed++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(1'b0, b, 16'($urandom));
    endtask

    task automatic send_start(input logic [15:0] sp);
        send_item(1'b1, 8'($urandom), sp);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    function automatic void append_text(ref logic [7:0] q [$], input string s);
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
    endfunction

    // Mostly well-formed header blocks; some lines get a stray byte and some
    // blocks are cut short by the next block start.
    task automatic random_block();
        logic [7:0] line [$];
        logic [7:0] c;
        string      name;
        int         lines;
        int         n;
        if ($urandom_range(0, 7) == 0)
            send_start(16'($urandom_range(16'hffc0, 16'hffff)));
        else
            send_start(16'($urandom));
        lines = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 6);
        for (int l = 0; l < lines; l++)
        begin
            line.delete();
            if ($urandom_range(0, 9) < 6)
            begin
                name = known_names[($urandom_range(0, 1) == 0) ? $urandom_range(0, 2)
                                                                : $urandom_range(0, 8)];
                for (int i = 0; i < name.len(); i++)
                begin
                    c = name[i];
                    if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1)
                        c = c - 8'd32;
                    line.push_back(c);
                end
            end
            else
            begin
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++)
                begin
                    do c = 8'($urandom_range(33, 126)); while (!header_scoreboard::is_token(c));
                    line.push_back(c);
                end
            end
            line.push_back(CH_COLON);
            n = $urandom_range(0, 2);
            for (int i = 0; i < n; i++)
                line.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            n = $urandom_range(0, 10);
            for (int i = 0; i < n; i++)
                line.push_back(8'($urandom_range(32, 126)));
            append_text(line, "\r\n");
            if ($urandom_range(0, 9) == 0)
                line[$urandom_range(0, line.size() - 1)] = 8'($urandom);
            foreach (line[i])
                send_byte(line[i]);
        end
        if ($urandom_range(0, 9) != 0)
        begin
            send_byte(CH_CR);
            send_byte(CH_LF);
        end
        if ($urandom_range(0, 4) == 0)
            send_byte(8'($urandom));
    endtask

    task automatic write_regs(input logic [31:0] seed, input logic [31:0] limit);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_HASH_SEED;
        cfg_data  <= seed;
        do @(posedge clk); while (!cfg_ready);
        parser_sb.write_config(CFG_HASH_SEED, seed);
        cfg_index <= CFG_OVERFLOW_LIMIT;
        cfg_data  <= limit;
        do @(posedge clk); while (!cfg_ready);
        parser_sb.write_config(CFG_OVERFLOW_LIMIT, limit);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every expected result, then let the pipe empty.
    task automatic settle();
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        while (parser_sb.expected_events.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (6) @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] seeds [5];
        logic [31:0] limits [5];
        int          target;
        parser_sb = new();
        in_valid       <= 1'b0;
        cmd            <= 1'b0;
        data_byte      <= 8'd0;
        start_position <= '0;
        cfg_valid      <= 1'b0;
        cfg_index      <= CFG_HASH_SEED;
        cfg_data       <= 32'd0;
        in_burst = 1'b0;
        fed = 0;
        seeds  = '{32'd0, 32'hffff_ffff, 32'd0, $urandom, 32'd0};
        limits = '{32'd16, 32'd0, 32'd2, 32'd31, 32'd1};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_regs(32'd0, 32'd16);

        // empty first line, then bytes after the error are dropped
        send_start(16'hfffe);
        send_byte(CH_CR);
        send_byte("Q");
        // empty key across the offset wrap, tab inside a value
        send_start(16'hffff);
        send_byte(CH_COLON);
        send_byte(CH_TAB);
        send_byte(CH_TILDE);
        send_byte(CH_TAB);
        // known header and a complete block, then a dropped byte
        send_start(16'h0000);
        send_text("Host: x");
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte("A");
        send_start(16'h1234);
        send_byte(8'hff);

        for (int ph = 0; ph < 5; ph++)
        begin
            settle();
            write_regs(seeds[ph], limits[ph]);
            target = fed + 140;
            while (fed < target)
                random_block();
        end
        settle();
        parser_sb.flag_leftovers();
        if (parser_sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
